[design/gdas_pkg.sv]
`timescale 1ns / 1ps

package gdas_pkg;

  // Default clamp for the day offset
  localparam int MAX_OFFSET_DEF = 65535;

  // Operation codes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // Calendar constants
  localparam logic [3:0]  MONTH_FIRST     = 4'd1;
  localparam logic [3:0]  MONTH_LAST      = 4'd12;
  localparam logic [14:0] YEAR_MIN        = 15'd1601;
  localparam logic [14:0] YEAR_MAX        = 15'd9999;
  localparam logic [8:0]  CYCLE_LAST      = 9'd399;
  localparam logic [8:0]  CENTURY_1       = 9'd100;
  localparam logic [8:0]  CENTURY_2       = 9'd200;
  localparam logic [8:0]  CENTURY_3       = 9'd300;
  localparam int          MOD_BASE        = 400;
  localparam logic [2:0]  MOD_STEPS_LAST  = 3'd5;
  localparam logic [4:0]  FEB_LEAP_DAYS   = 5'd29;
  localparam logic [3:0]  MONTH_FEB       = 4'd2;

  // Month lengths, non-leap; codes outside 1..12 have no days
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef struct packed {
    logic        operation;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic [15:0] day_offset;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic        date_valid;
    logic        range_error;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mod_step;
    logic check;
    logic walk_step;
    logic finish;
  } gdas_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_last;
    logic date_ok;
    logic walk_done;
    logic out_free;
  } gdas_status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_CHECK = 5'b00100,
    S_WALK  = 5'b01000,
    S_DONE  = 5'b10000
  } gdas_state_t;

  // Leap test on the year modulo 400
  function automatic logic is_leap(input logic [8:0] r);
    return (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2) && (r != CENTURY_3);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = MONTH_LEN[m];
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP_DAYS;
    end
    return len;
  endfunction

  // Restoring-reduction threshold: 400 shifted by the step number
  function automatic logic [13:0] mod_thresh(input logic [2:0] k);
    return 14'(MOD_BASE << k);
  endfunction

endpackage

[design/gdas_ctrl.sv]
`timescale 1ns / 1ps

module gdas_ctrl import gdas_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  gdas_status_t status,
  output gdas_cmd_t    cmd
);

  gdas_state_t state;
  gdas_state_t state_next;

  // Hold state, clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one item: load, reduce year, check, walk, deliver
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_next = status.date_ok ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (status.walk_done) begin
          state_next = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/gdas_dp.sv]
`timescale 1ns / 1ps

module gdas_dp import gdas_pkg::*; #(
  parameter int MAX_OFFSET = MAX_OFFSET_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  in_beat_t     in_data,
  input  gdas_cmd_t    cmd,
  output gdas_status_t status,
  output out_beat_t    out_data,
  output logic         out_valid,
  input  logic         out_ready
);

  localparam int SUM_W = ($clog2(MAX_OFFSET + 64) > 16) ? $clog2(MAX_OFFSET + 64) : 16;
  localparam int ACC_W = SUM_W + 1;

  logic signed [ACC_W-1:0] d;
  logic        [ACC_W-1:0] off;
  logic        [3:0]       m;
  logic        [14:0]      y;
  logic        [13:0]      rw;
  logic        [2:0]       k;
  logic                    op;
  logic                    valid;

  logic        [ACC_W-1:0] off_ext;
  logic        [13:0]      thr;
  logic        [8:0]       r;
  logic        [8:0]       r_up;
  logic        [8:0]       r_dn;
  logic        [8:0]       r_prev;
  logic        [3:0]       m_prev;
  logic        [4:0]       dim_cur;
  logic        [4:0]       dim_prev;
  logic signed [ACC_W-1:0] dim_cur_s;
  logic signed [ACC_W-1:0] dim_prev_s;
  logic                    in_range;

  assign off_ext    = {{(ACC_W-16){1'b0}}, in_data.day_offset};
  assign thr        = mod_thresh(k);
  assign r          = rw[8:0];
  assign r_up       = (r == CYCLE_LAST) ? 9'd0 : r + 9'd1;
  assign r_dn       = (r == 9'd0) ? CYCLE_LAST : r - 9'd1;
  assign m_prev     = (m == MONTH_FIRST) ? MONTH_LAST : m - 4'd1;
  assign r_prev     = (m == MONTH_FIRST) ? r_dn : r;
  assign dim_cur    = month_days(m, is_leap(r));
  assign dim_prev   = month_days(m_prev, is_leap(r_prev));
  assign dim_cur_s  = signed'({{(ACC_W-5){1'b0}}, dim_cur});
  assign dim_prev_s = signed'({{(ACC_W-5){1'b0}}, dim_prev});
  assign in_range   = (y >= YEAR_MIN) && (y <= YEAR_MAX);

  // Status back to the controller
  assign status.mod_last  = (k == 3'd0);
  assign status.date_ok   = (y >= YEAR_MIN) && (m >= MONTH_FIRST) && (m <= MONTH_LAST) &&
                            (d >= signed'(ACC_W'(1))) && (d <= dim_cur_s);
  assign status.walk_done = op ? (d >= signed'(ACC_W'(1))) : (d <= dim_cur_s);
  assign status.out_free  = !out_valid || out_ready;

  // Working registers: load, reduce year mod 400, apply offset, walk months
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_data.operation;
      d     <= signed'({{(ACC_W-5){1'b0}}, in_data.in_day});
      m     <= in_data.in_month;
      y     <= {1'b0, in_data.in_year};
      rw    <= in_data.in_year;
      k     <= MOD_STEPS_LAST;
      off   <= (off_ext > ACC_W'(MAX_OFFSET)) ? ACC_W'(MAX_OFFSET) : off_ext;
      valid <= 1'b0;
    end else if (cmd.mod_step) begin
      if (rw >= thr) begin
        rw <= rw - thr;
      end
      k <= k - 3'd1;
    end else if (cmd.check) begin
      valid <= status.date_ok;
      if (status.date_ok) begin
        d <= op ? d - signed'(off) : d + signed'(off);
      end
    end else if (cmd.walk_step) begin
      if (!op) begin
        // Forward: drop this month's days and advance
        d <= d - dim_cur_s;
        if (m == MONTH_LAST) begin
          m  <= MONTH_FIRST;
          y  <= y + 15'd1;
          rw <= {5'd0, r_up};
        end else begin
          m <= m + 4'd1;
        end
      end else begin
        // Backward: step to the prior month and add its days
        d  <= d + dim_prev_s;
        m  <= m_prev;
        rw <= {5'd0, r_prev};
        if (m == MONTH_FIRST) begin
          y <= y - 15'd1;
        end
      end
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.out_day     <= d[4:0];
      out_data.out_month   <= m;
      out_data.out_year    <= y[13:0];
      out_data.date_valid  <= valid;
      out_data.range_error <= valid && !in_range;
    end
  end

endmodule

[design/gregorian_date_add_sub_days.sv]
`timescale 1ns / 1ps
// An input beat passes through load, year reduction mod 400, date check, the month walk
// (one step per month crossed, up to about 2200 for a 65535-day offset) and delivery;
// an invalid date skips the walk. The block takes one item at a time; the month walk
// steps one month per cycle, and a result that waits in the output register holds
// the next item in its final state until it is taken.
// Reset (synchronous, active high) clears the controller and the output valid.

module gregorian_date_add_sub_days import gdas_pkg::*; #(
  parameter int MAX_OFFSET = MAX_OFFSET_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  gdas_cmd_t    cmd;
  gdas_status_t status;

  gdas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gdas_dp #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

[tb/date_shift_monitor.sv]
`timescale 1ns / 1ps

module date_shift_monitor import gdas_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  output int        mismatches,
  output int        outstanding
);

  // Non-leap month lengths, index 0 unused
  localparam int DAYS_PER_MONTH [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  out_beat_t expected_dates [$];
  out_beat_t want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic bit leap_year(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_length(int m, int y);
    if (m < MONTH_FIRST || m > MONTH_LAST) begin
      return 0;
    end
    if (m == MONTH_FEB && leap_year(y)) begin
      return 29;
    end
    return DAYS_PER_MONTH[m];
  endfunction

  // Expected result of shifting a date by the offset, one month at a time
  function automatic out_beat_t shift_date(in_beat_t b);
    int d;
    int m;
    int y;
    int off;
    bit ok;
    out_beat_t r;
    d   = b.in_day;
    m   = b.in_month;
    y   = b.in_year;
    off = b.day_offset;
    if (off > MAX_OFFSET_DEF) begin
      off = MAX_OFFSET_DEF;
    end
    ok = (y >= YEAR_MIN) && (m >= MONTH_FIRST) && (m <= MONTH_LAST) &&
         (d >= 1) && (d <= month_length(m, y));
    r.range_error = 1'b0;
    if (ok) begin
      if (b.operation != OP_SUB) begin
        d += off;
        while (d > month_length(m, y)) begin
          d -= month_length(m, y);
          if (m == MONTH_LAST) begin
            m = MONTH_FIRST;
            y += 1;
          end else begin
            m += 1;
          end
        end
      end else begin
        d -= off;
        while (d < 1) begin
          m -= 1;
          if (m < MONTH_FIRST) begin
            m = MONTH_LAST;
            y -= 1;
          end
          d += month_length(m, y);
        end
      end
      r.range_error = (y < YEAR_MIN) || (y > YEAR_MAX);
    end
    r.out_day    = 5'(d);
    r.out_month  = 4'(m);
    r.out_year   = 14'(y);
    r.date_valid = ok;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Compare each returned beat against the oldest prediction, then queue new ones
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing pending", out_data));
        end else begin
          want = expected_dates.pop_front();
          if (out_data.out_day !== want.out_day) begin
            report_mismatch($sformatf("out_day got %0d expected %0d",
                                      out_data.out_day, want.out_day));
          end
          if (out_data.out_month !== want.out_month) begin
            report_mismatch($sformatf("out_month got %0d expected %0d",
                                      out_data.out_month, want.out_month));
          end
          if (out_data.out_year !== want.out_year) begin
            report_mismatch($sformatf("out_year got %0d expected %0d",
                                      out_data.out_year, want.out_year));
          end
          if (out_data.date_valid !== want.date_valid) begin
            report_mismatch($sformatf("date_valid got %0b expected %0b",
                                      out_data.date_valid, want.date_valid));
          end
          if (out_data.range_error !== want.range_error) begin
            report_mismatch($sformatf("range_error got %0b expected %0b",
                                      out_data.range_error, want.range_error));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_dates.push_back(shift_date(in_data));
      end
    end
    outstanding <= expected_dates.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench import gdas_pkg::*; ();

  localparam int     NUM_RANDOM   = 250;
  localparam int     MAX_IDLE     = 17;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT  = 3_000_000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  int        mismatches;
  int        outstanding;
  longint    cycles = 0;
  bit        send_burst = 1'b0;
  bit        recv_burst = 1'b0;

  gregorian_date_add_sub_days dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  date_shift_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_beat_t make_beat(logic op, int d, int m, int y, int off);
    in_beat_t b;
    b.operation  = op;
    b.in_day     = 5'(d);
    b.in_month   = 4'(m);
    b.in_year    = 14'(y);
    b.day_offset = 16'(off);
    return b;
  endfunction

  // Mostly well-formed dates with random content, some broken or pure noise
  function automatic in_beat_t random_date();
    int kind;
    int pick;
    int y;
    int d;
    int off;
    in_beat_t b;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      b.operation  = 1'($urandom);
      b.in_day     = 5'($urandom);
      b.in_month   = 4'($urandom);
      b.in_year    = 14'($urandom);
      b.day_offset = 16'($urandom);
      return b;
    end
    pick = $urandom_range(0, 9);
    if (kind < 20) begin
      y = $urandom_range(0, 1600);
    end else if (pick < 6) begin
      y = $urandom_range(1601, 9999);
    end else if (pick == 6) begin
      y = $urandom_range(1601, 1700);
    end else if (pick == 7) begin
      y = $urandom_range(9900, 10100);
    end else if (pick == 8) begin
      y = $urandom_range(10000, 16383);
    end else begin
      y = $urandom_range(1601, 2400);
    end
    // month ends are hit often; 29 to 31 is sometimes past the end
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      off = $urandom_range(0, 400);
    end else if (pick < 7) begin
      off = $urandom_range(0, 65535);
    end else if (pick < 9) begin
      off = $urandom_range(60000, 65535);
    end else begin
      off = $urandom_range(0, 40);
    end
    return make_beat(1'($urandom), d, $urandom_range(MONTH_FIRST, MONTH_LAST), y, off);
  endfunction

  // Idle a random number of cycles, then hold the beat until it is taken
  task automatic send_date(in_beat_t b);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(0, 15) == 0) begin
      send_burst = !send_burst;
    end
  endtask

  // Result side: stall a random number of cycles before each beat
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      if ($urandom_range(0, 15) == 0) begin
        recv_burst = !recv_burst;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Range edges, leap rules and malformed dates
    send_date(make_beat(OP_ADD, 1, 1, 1601, 0));
    send_date(make_beat(OP_SUB, 1, 1, 1601, 1));
    send_date(make_beat(OP_ADD, 1, 1, 1601, 65535));
    send_date(make_beat(OP_SUB, 1, 1, 1601, 65535));
    send_date(make_beat(OP_ADD, 29, 2, 2000, 1));
    send_date(make_beat(OP_ADD, 29, 2, 1900, 1));
    send_date(make_beat(OP_SUB, 29, 2, 2004, 365));
    send_date(make_beat(OP_ADD, 28, 2, 2100, 1));
    send_date(make_beat(OP_ADD, 31, 12, 9999, 1));
    send_date(make_beat(OP_SUB, 1, 1, 10000, 1));
    send_date(make_beat(OP_ADD, 31, 12, 16383, 65535));
    send_date(make_beat(OP_SUB, 15, 6, 16383, 65535));
    send_date(make_beat(OP_ADD, 0, 5, 2020, 10));
    send_date(make_beat(OP_SUB, 31, 4, 2021, 10));
    send_date(make_beat(OP_ADD, 10, 0, 2021, 10));
    send_date(make_beat(OP_ADD, 31, 13, 2021, 10));
    send_date(make_beat(OP_SUB, 31, 15, 2021, 10));
    send_date(make_beat(OP_ADD, 1, 1, 0, 5));
    send_date(make_beat(OP_ADD, 31, 12, 1600, 5));
    send_date(make_beat(OP_ADD, 31, 1, 2023, 31));
    send_date(make_beat(OP_SUB, 31, 12, 2023, 365));
    send_date(make_beat(OP_SUB, 1, 3, 2024, 1));
    send_date(make_beat(OP_SUB, 31, 15, 16383, 65535));
    send_date(make_beat(OP_ADD, 0, 0, 0, 0));

    repeat (NUM_RANDOM) send_date(random_date());
    in_valid <= 1'b0;

    // let the last prediction reach the pending count, then drain
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
